>>> hw/rtl/kmp_pkg.sv
`default_nettype none

package kmp_pkg;

    // Command codes carried in s_tuser
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_END    = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APP_CMP,
        ST_TXT_CMP,
        ST_EMIT
    } state_t;

    localparam int START_BITS   = 16;
    localparam int OUT_POS_BITS = 16;
    localparam int BYTE_BITS    = 8;

    // Controller -> datapath
    typedef struct packed {
        logic clear_pat;   // drop pattern
        logic restart;     // reset text search state
        logic app_write;   // store pattern byte at index len
        logic app_first;   // first pattern byte: table entry 1 = 0
        logic app_lookup;  // start failure walk at build pointer
        logic txt_step;    // advance text position, capture byte
        logic txt_lookup;  // start match walk at match pointer
        logic follow;      // take failure link from table read data
        logic use_j;       // walk ended on a hit (else pointer is zero)
        logic app_finish;  // write table entry, grow pattern
        logic txt_finish;  // update match pointer / record match
        logic emit;        // load result register
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic len_full;
        logic len_zero;
        logic bp_zero;
        logic txt_skip;
        logic txt_start_ok;
        logic cmp_eq;
        logic f_zero;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/kmp_ram.sv
`default_nettype none

module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/kmp_ctrl.sv
`default_nettype none

module kmp_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [1:0]           cmd_code,
    input  wire kmp_pkg::dp_status_t  status,
    output kmp_pkg::dp_cmd_t          cmd
);

    kmp_pkg::state_t state_reg, state_next;
    logic            take;

    assign s_tready = (state_reg == kmp_pkg::ST_IDLE);
    assign take     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kmp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            kmp_pkg::ST_IDLE: begin
                if (take) begin
                    case (cmd_code)
                        kmp_pkg::CMD_APPEND: begin
                            if (!status.len_full && !status.len_zero && !status.bp_zero) begin
                                state_next = kmp_pkg::ST_APP_CMP;
                            end
                        end
                        kmp_pkg::CMD_TEXT: begin
                            if (!status.txt_skip && status.txt_start_ok) begin
                                state_next = kmp_pkg::ST_TXT_CMP;
                            end
                        end
                        kmp_pkg::CMD_END: state_next = kmp_pkg::ST_EMIT;
                        default:          state_next = kmp_pkg::ST_IDLE;
                    endcase
                end
            end
            kmp_pkg::ST_APP_CMP, kmp_pkg::ST_TXT_CMP: begin
                if (status.cmp_eq || status.f_zero) begin
                    state_next = kmp_pkg::ST_IDLE;
                end
            end
            kmp_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    state_next = kmp_pkg::ST_IDLE;
                end
            end
            default: state_next = kmp_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        cmd = '0;
        case (state_reg)
            kmp_pkg::ST_IDLE: begin
                if (take) begin
                    case (cmd_code)
                        kmp_pkg::CMD_CLEAR: begin
                            cmd.clear_pat = 1'b1;
                            cmd.restart   = 1'b1;
                        end
                        kmp_pkg::CMD_APPEND: begin
                            if (!status.len_full) begin
                                cmd.app_write = 1'b1;
                                if (status.len_zero) begin
                                    cmd.app_first = 1'b1;
                                end else if (status.bp_zero) begin
                                    cmd.app_finish = 1'b1;
                                end else begin
                                    cmd.app_lookup = 1'b1;
                                end
                            end
                        end
                        kmp_pkg::CMD_TEXT: begin
                            if (!status.txt_skip) begin
                                cmd.txt_step   = 1'b1;
                                cmd.txt_lookup = status.txt_start_ok;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            kmp_pkg::ST_APP_CMP: begin
                cmd.use_j = status.cmp_eq;
                if (status.cmp_eq || status.f_zero) begin
                    cmd.app_finish = 1'b1;
                end else begin
                    cmd.follow = 1'b1;
                end
            end
            kmp_pkg::ST_TXT_CMP: begin
                cmd.use_j = status.cmp_eq;
                if (status.cmp_eq || status.f_zero) begin
                    cmd.txt_finish = 1'b1;
                end else begin
                    cmd.follow = 1'b1;
                end
            end
            kmp_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.restart = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/kmp_datapath.sv
`default_nettype none

module kmp_datapath #(
    parameter int PATTERN_MAX   = 256,
    parameter int POSITION_BITS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire kmp_pkg::dp_cmd_t                  cmd,
    output kmp_pkg::dp_status_t                    status,
    input  wire logic [kmp_pkg::BYTE_BITS-1:0]     data_in,
    input  wire logic                              cfg_we,
    input  wire logic [kmp_pkg::START_BITS-1:0]    cfg_data,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic                                   out_found,
    output logic [kmp_pkg::OUT_POS_BITS-1:0]       out_pos
);

    localparam int PW = $clog2(PATTERN_MAX + 1);
    localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CW = (POSITION_BITS > kmp_pkg::START_BITS) ? POSITION_BITS
                                                               : kmp_pkg::START_BITS;
    localparam int BB = kmp_pkg::BYTE_BITS;
    localparam int SB = kmp_pkg::START_BITS;
    localparam int OB = kmp_pkg::OUT_POS_BITS;

    // architectural state
    logic [SB-1:0]            start_reg, start_next;
    logic [PW-1:0]            len_reg, len_next;
    logic [PW-1:0]            bp_reg, bp_next;
    logic [PW-1:0]            mp_reg, mp_next;
    logic [POSITION_BITS-1:0] tp_reg, tp_next;
    logic                     done_reg, done_next;
    logic [OB-1:0]            found_reg, found_next;
    // walk working registers
    logic [BB-1:0]            last_reg, last_next;
    logic [BB-1:0]            byte_reg, byte_next;
    logic [BB-1:0]            key_reg, key_next;
    logic [PW-1:0]            j_reg, j_next;
    // result register
    logic                     ov_reg, ov_next;
    logic                     of_reg, of_next;
    logic [OB-1:0]            op_reg, op_next;

    // memories
    logic [BB-1:0] p_rdata;
    logic [PW-1:0] f_rdata;
    logic [AW-1:0] rd_addr;
    logic          f_we;
    logic [PW-1:0] f_wdata;
    logic [AW-1:0] f_waddr;

    logic [PW-1:0] rd_ptr;
    logic [PW-1:0] rd_ptr_m1;
    logic [PW-1:0] mp_clamp;
    logic [PW-1:0] j_end;
    logic [PW:0]   j1;
    logic [SB-1:0] eff_start;
    logic [POSITION_BITS-1:0] tp_inc;
    logic [CW-1:0] found_full;

    kmp_ram #(.WIDTH(BB), .DEPTH(PATTERN_MAX)) u_pat_ram (
        .aclk  (aclk),
        .we    (cmd.app_write),
        .waddr (len_reg[AW-1:0]),
        .wdata (data_in),
        .raddr (rd_addr),
        .rdata (p_rdata)
    );

    kmp_ram #(.WIDTH(PW), .DEPTH(PATTERN_MAX)) u_fail_ram (
        .aclk  (aclk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (rd_addr),
        .rdata (f_rdata)
    );

    assign eff_start = (start_reg == '0) ? SB'(1) : start_reg;
    assign tp_inc    = tp_reg + POSITION_BITS'(1);
    assign mp_clamp  = ((mp_reg == '0) || (mp_reg > len_reg)) ? PW'(1) : mp_reg;

    // read pointer (1-based) for the next table/pattern lookup
    always_comb begin
        if (cmd.follow) begin
            rd_ptr = f_rdata;
        end else if (cmd.txt_lookup) begin
            rd_ptr = mp_clamp;
        end else begin
            rd_ptr = bp_reg;
        end
    end
    assign rd_ptr_m1 = rd_ptr - PW'(1);
    assign rd_addr   = rd_ptr_m1[AW-1:0];

    assign j_end = cmd.use_j ? j_reg : '0;
    assign j1    = {1'b0, j_end} + (PW+1)'(1);

    // failure table write: entry 1 on the first byte, entry len+1 at walk end
    assign f_we    = cmd.app_first || cmd.app_finish;
    assign f_wdata = cmd.app_first ? '0 : j1[PW-1:0];
    assign f_waddr = len_reg[AW-1:0];

    assign found_full = CW'(tp_reg) + CW'(1) - CW'(len_reg);

    always_comb begin
        status.len_full     = (len_reg == PW'(PATTERN_MAX));
        status.len_zero     = (len_reg == '0);
        status.bp_zero      = (bp_reg == '0);
        status.txt_skip     = done_reg || (&tp_reg);
        status.txt_start_ok = (CW'(tp_inc) >= CW'(eff_start)) && (len_reg != '0);
        status.cmp_eq       = (p_rdata == key_reg);
        status.f_zero       = (f_rdata == '0);
        status.out_free     = !ov_reg || out_ready;
    end

    always_comb begin
        start_next = start_reg;
        len_next   = len_reg;
        bp_next    = bp_reg;
        mp_next    = mp_reg;
        tp_next    = tp_reg;
        done_next  = done_reg;
        found_next = found_reg;
        last_next  = last_reg;
        byte_next  = byte_reg;
        key_next   = key_reg;
        j_next     = j_reg;
        ov_next    = ov_reg && !out_ready;
        of_next    = of_reg;
        op_next    = op_reg;

        if (cfg_we) begin
            start_next = cfg_data;
        end

        if (cmd.app_write) begin
            byte_next = data_in;
        end
        if (cmd.app_first) begin
            len_next  = PW'(1);
            bp_next   = '0;
            last_next = data_in;
        end
        if (cmd.app_lookup) begin
            key_next = last_reg;
        end
        if (cmd.app_lookup || cmd.txt_lookup || cmd.follow) begin
            j_next = rd_ptr;
        end
        if (cmd.app_finish) begin
            bp_next   = j1[PW-1:0];
            len_next  = len_reg + PW'(1);
            last_next = cmd.app_write ? data_in : byte_reg;
        end

        if (cmd.txt_step) begin
            tp_next = tp_inc;
        end
        if (cmd.txt_lookup) begin
            key_next = data_in;
        end
        if (cmd.txt_finish) begin
            if (j1 > {1'b0, len_reg}) begin
                done_next  = 1'b1;
                found_next = found_full[OB-1:0];
                mp_next    = PW'(1);
            end else begin
                mp_next = j1[PW-1:0];
            end
        end

        if (cmd.emit) begin
            ov_next = 1'b1;
            if (len_reg == '0) begin
                of_next = 1'b1;
                op_next = OB'(eff_start);
            end else if (done_reg) begin
                of_next = 1'b1;
                op_next = found_reg;
            end else begin
                of_next = 1'b0;
                op_next = '0;
            end
        end

        if (cmd.clear_pat) begin
            len_next = '0;
            bp_next  = '0;
        end
        if (cmd.restart) begin
            mp_next    = PW'(1);
            tp_next    = '0;
            done_next  = 1'b0;
            found_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= SB'(1);
            len_reg   <= '0;
            bp_reg    <= '0;
            mp_reg    <= PW'(1);
            tp_reg    <= '0;
            done_reg  <= 1'b0;
            found_reg <= '0;
            ov_reg    <= 1'b0;
        end else begin
            start_reg <= start_next;
            len_reg   <= len_next;
            bp_reg    <= bp_next;
            mp_reg    <= mp_next;
            tp_reg    <= tp_next;
            done_reg  <= done_next;
            found_reg <= found_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg <= last_next;
        byte_reg <= byte_next;
        key_reg  <= key_next;
        j_reg    <= j_next;
        of_reg   <= of_next;
        op_reg   <= op_next;
    end

    assign out_valid = ov_reg;
    assign out_found = of_reg;
    assign out_pos   = op_reg;

endmodule

`default_nettype wire

>>> hw/rtl/kmp_substring_search_unit.sv
`default_nettype none

// Sequencing: clear, an ignored byte or a skipped text byte is handled in the idle state;
//   a pattern append or searched text byte that needs a lookup walks the failure links,
//   one pattern/table read per link visited; end of text waits in ST_EMIT until the
//   result register is free, then loads it and raises m_tvalid. One transaction at a time,
//   since the pattern and failure-table memories share a single read address.
// Reset (aresetn low, synchronous): empty pattern, search state cleared, start_position 1,
//   no result pending. Memory contents are not cleared; no clearing pass is needed.

module kmp_substring_search_unit #(
    parameter int PATTERN_MAX   = 256,  // pattern capacity in bytes
    parameter int POSITION_BITS = 16    // width of the text position counter
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] command

    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] match_position
    output logic             m_tuser,   // [0] found

    // start_position register write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data   // [15:0] start_position
);

    kmp_pkg::dp_cmd_t    cmd;
    kmp_pkg::dp_status_t status;

    // Register writes should only happen while idle; the block itself does not enforce this. The port never stalls.
    assign cfg_ready = 1'b1;

    // Controller: sequences each transaction and the failure-link walks.
    kmp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd_code (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: pattern and failure-table memories, pointers, result register.
    kmp_datapath #(
        .PATTERN_MAX   (PATTERN_MAX),
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .data_in   (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_found (m_tuser),
        .out_pos   (m_tdata)
    );

endmodule

`default_nettype wire

>>> dv/kmp_search_checker.sv
module kmp_search_checker
    import kmp_pkg::*;
#(
    parameter int PATTERN_MAX   = 256,
    parameter int POSITION_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    input  wire logic        m_tuser,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        run_done,
    output int               mismatch_count,
    output int               results_pending
);

    localparam longint unsigned POS_LIMIT = (64'd1 << POSITION_BITS) - 64'd1;

    typedef struct packed {
        logic        found;
        logic [15:0] position;
    } search_result_t;

    // search state, 1-based like the hardware tables
    logic [7:0]      pattern_bytes [1:PATTERN_MAX];
    int unsigned     failure_links [1:PATTERN_MAX];
    int unsigned     pat_len;
    int unsigned     build_ptr;
    int unsigned     match_ptr;
    longint unsigned text_pos;
    longint unsigned hit_pos;
    bit              hit;
    logic [15:0]     start_pos;

    search_result_t  expected_verdicts [$];
    search_result_t  want;

    initial mismatch_count = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR kmp search: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int unsigned first_position();
        return (start_pos == 16'd0) ? 1 : int'(start_pos);
    endfunction

    function automatic void restart_search();
        match_ptr = 1;
        text_pos  = 0;
        hit       = 1'b0;
        hit_pos   = 0;
    endfunction

    function automatic void add_pattern_byte(input logic [7:0] b);
        int unsigned n;
        int unsigned j;
        if (pat_len >= PATTERN_MAX) return;
        n = pat_len + 1;
        pattern_bytes[n] = b;
        if (n == 1) begin
            failure_links[1] = 0;
            build_ptr = 0;
        end else begin
            j = build_ptr;
            while (j != 0 && j <= PATTERN_MAX && pattern_bytes[n - 1] != pattern_bytes[j])
                j = failure_links[j];
            j++;
            failure_links[n] = j;
            build_ptr = j;
        end
        pat_len = n;
    endfunction

    function automatic void scan_text_byte(input logic [7:0] c);
        int unsigned j;
        if (hit || text_pos >= POS_LIMIT) return;
        text_pos++;
        if (text_pos < first_position() || pat_len == 0) return;
        j = match_ptr;
        if (j == 0 || j > pat_len) j = 1;
        while (j != 0 && pattern_bytes[j] != c)
            j = failure_links[j];
        j++;
        if (j > pat_len) begin
            hit       = 1'b1;
            hit_pos   = text_pos + 1 - pat_len;
            match_ptr = 1;
        end else begin
            match_ptr = j;
        end
    endfunction

    function automatic search_result_t close_text();
        search_result_t r;
        if (pat_len == 0) begin
            r.found    = 1'b1;
            r.position = 16'(first_position());
        end else if (hit) begin
            r.found    = 1'b1;
            r.position = hit_pos[15:0];
        end else begin
            r = '0;
        end
        restart_search();
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            start_pos = 16'd1;
            pat_len   = 0;
            build_ptr = 0;
            restart_search();
            expected_verdicts.delete();
        end else begin
            // results first: an end-of-text never completes at its own accept edge
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("unexpected result found=%0b position=%0d",
                                              m_tuser, m_tdata));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_tuser !== want.found)
                        report_mismatch($sformatf("found got %0b want %0b",
                                                  m_tuser, want.found));
                    if (m_tdata !== want.position)
                        report_mismatch($sformatf("match_position got %0d want %0d",
                                                  m_tdata, want.position));
                end
            end
            if (cfg_valid && cfg_ready)
                start_pos = cfg_data;
            if (s_tvalid && s_tready) begin
                case (cmd_code_t'(s_tuser))
                    CMD_CLEAR: begin
                        pat_len   = 0;
                        build_ptr = 0;
                        restart_search();
                    end
                    CMD_APPEND: add_pattern_byte(s_tdata);
                    CMD_TEXT:   scan_text_byte(s_tdata);
                    default:    expected_verdicts.push_back(close_text());
                endcase
            end
            if (run_done && expected_verdicts.size() != 0) begin
                report_mismatch($sformatf("%0d results never arrived",
                                          expected_verdicts.size()));
                expected_verdicts.delete();
            end
        end
        results_pending <= expected_verdicts.size();
    end

endmodule

>>> dv/tb_kmp_substring_search_unit.sv
module tb_kmp_substring_search_unit;
    import kmp_pkg::*;

    localparam int PATTERN_MAX    = 256;
    localparam int POSITION_BITS  = 16;
    localparam int RANDOM_ITEMS   = 1400;  // rough size of the random part
    localparam int CALM_TAIL      = 300;   // last random items run without idling
    localparam int SETTLE_CYCLES  = 300;   // covers a full failure walk on a 256-byte pattern
    localparam int RX_HOLD_CYCLES = 200;   // long receiver hold-off
    localparam int QUIET_LIMIT    = 5000;  // cycles with no transaction before giving up

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] data_byte
    logic [1:0]  s_tuser;    // [1:0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [15:0] match_position
    logic        m_tuser;    // [0] found
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;   // [15:0] start_position
    logic        run_done;

    int          mismatch_count;
    int          results_pending;

    bit          idle_on     = 1'b1;  // random idle bursts on both sides
    bit          rx_hold_req = 1'b0;  // asks the result sink for one long hold-off
    int          items_sent  = 0;
    logic [7:0]  cur_pat [$];         // pattern as sent, used to plant matches in text

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    kmp_substring_search_unit #(
        .PATTERN_MAX   (PATTERN_MAX),
        .POSITION_BITS (POSITION_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    kmp_search_checker #(
        .PATTERN_MAX   (PATTERN_MAX),
        .POSITION_BITS (POSITION_BITS)
    ) u_search_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .run_done        (run_done),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // One input transaction. Handshake signals are read right at the edge, so
    // they hold the values the block saw when it took the transaction.
    task automatic send_item(input cmd_code_t cmd, input logic [7:0] b);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (cmd == CMD_CLEAR)
            cur_pat.delete();
        else if (cmd == CMD_APPEND && cur_pat.size() < PATTERN_MAX)
            cur_pat.push_back(b);
    endtask

    // Stop offering and wait for every outstanding result. The first edge
    // lets the checker's count catch up with the last accepted transaction.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
    endtask

    // start_position only changes while the block is idle; a text byte with
    // no result may still be walking the table, hence the settle time.
    task automatic write_start_position(input logic [15:0] v);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Text mostly drawn from the pattern's own bytes so partial matches and
    // failure links get exercised; now and then a stray byte.
    function automatic logic [7:0] pick_text_byte();
        if (cur_pat.size() == 0 || $urandom_range(0, 7) == 0)
            return 8'($urandom_range(0, 255));
        return cur_pat[$urandom_range(0, cur_pat.size() - 1)];
    endfunction

    // Well-formed search: optional new pattern, text with an optional planted
    // copy of the pattern and rare appends mid-text, then end of text.
    task automatic run_search_sequence();
        logic [7:0] sym [3];
        int         n_sym;
        int         plen;
        int         tlen;
        int         plant_at;
        n_sym = $urandom_range(1, 3);
        foreach (sym[k]) sym[k] = 8'($urandom_range(0, 255));
        if (cur_pat.size() == 0 || $urandom_range(0, 2) != 0) begin
            send_item(CMD_CLEAR, 8'($urandom_range(0, 255)));
            case ($urandom_range(0, 9))
                0: plen = 0;
                1: plen = $urandom_range(6, 40);
                default: plen = $urandom_range(1, 5);
            endcase
            repeat (plen) send_item(CMD_APPEND, sym[$urandom_range(0, n_sym - 1)]);
        end
        tlen     = $urandom_range(0, 30);
        plant_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, tlen) : -1;
        for (int k = 0; k <= tlen; k++) begin
            if (k == plant_at)
                foreach (cur_pat[m]) send_item(CMD_TEXT, cur_pat[m]);
            if (k == tlen)
                break;
            if ($urandom_range(0, 19) == 0)
                send_item(CMD_APPEND, sym[$urandom_range(0, n_sym - 1)]);
            else
                send_item(CMD_TEXT, pick_text_byte());
        end
        send_item(CMD_END, 8'($urandom_range(0, 255)));
    endtask

    // Result sink: random ready bursts, one long hold-off on request.
    initial begin : result_sink
        forever begin
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    // Watchdog: any transaction on any channel counts as progress.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] sym_a;
        logic [7:0] sym_b;
        int         random_base;
        bit         hold_done;
        logic [15:0] new_start;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        s_tuser   <= CMD_CLEAR;
        cfg_valid <= 1'b0;
        cfg_data  <= 16'h0000;
        run_done  <= 1'b0;
        hold_done = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed ----
        // empty pattern reports the reset start position
        send_item(CMD_END, 8'h00);
        // start position zero behaves as one
        write_start_position(16'd0);
        send_item(CMD_END, 8'hFF);

        // pattern 00 FF 00 with start 3: the occurrence at 1 is skipped,
        // the one at 3 is reported and the byte after it is ignored
        write_start_position(16'd3);
        send_item(CMD_APPEND, 8'h00);
        send_item(CMD_APPEND, 8'hFF);
        send_item(CMD_APPEND, 8'h00);
        send_item(CMD_TEXT, 8'h00);
        send_item(CMD_TEXT, 8'hFF);
        send_item(CMD_TEXT, 8'h00);
        send_item(CMD_TEXT, 8'hFF);
        send_item(CMD_TEXT, 8'h00);
        send_item(CMD_TEXT, 8'h00);
        send_item(CMD_END, 8'h00);

        // start beyond the end of the text: not found
        write_start_position(16'hFFFF);
        send_item(CMD_TEXT, 8'h00);
        send_item(CMD_TEXT, 8'hFF);
        send_item(CMD_TEXT, 8'h00);
        send_item(CMD_END, 8'hFF);

        // pattern grows while text is streaming
        write_start_position(16'd1);
        send_item(CMD_CLEAR, 8'hFF);
        send_item(CMD_APPEND, 8'h41);
        send_item(CMD_TEXT, 8'h42);
        send_item(CMD_APPEND, 8'h42);
        send_item(CMD_TEXT, 8'h41);
        send_item(CMD_TEXT, 8'h42);
        send_item(CMD_END, 8'h00);

        // ---- full pattern: appends past capacity are dropped ----
        sym_a = 8'h3C;
        sym_b = 8'hC3;
        send_item(CMD_CLEAR, 8'h00);
        for (int k = 0; k < PATTERN_MAX; k++)
            send_item(CMD_APPEND, $urandom_range(0, 1) ? sym_a : sym_b);
        repeat (4) send_item(CMD_APPEND, 8'h5A);
        repeat (5) send_item(CMD_TEXT, $urandom_range(0, 1) ? sym_a : sym_b);
        for (int k = 0; k < PATTERN_MAX; k++)
            send_item(CMD_TEXT, cur_pat[k]);
        send_item(CMD_TEXT, 8'h5A);
        send_item(CMD_END, 8'h00);

        // ---- random ----
        random_base = items_sent;
        while (items_sent - random_base < RANDOM_ITEMS) begin
            if (items_sent - random_base >= RANDOM_ITEMS - CALM_TAIL)
                idle_on = 1'b0;
            if (!hold_done && items_sent - random_base >= RANDOM_ITEMS / 2) begin
                // sender pauses until all results are in, then the sink holds
                // off while several end-of-text transactions back up the block
                hold_done = 1'b1;
                drain_results();
                rx_hold_req = 1'b1;
                for (int k = 0; k < 6; k++) begin
                    send_item(CMD_TEXT, pick_text_byte());
                    send_item(CMD_END, 8'h00);
                end
            end
            case ($urandom_range(0, 11))
                0: begin
                    // noise: any command, any byte
                    repeat ($urandom_range(1, 8))
                        send_item(cmd_code_t'($urandom_range(0, 3)),
                                  8'($urandom_range(0, 255)));
                end
                1: begin
                    case ($urandom_range(0, 7))
                        0: new_start = 16'd0;
                        1: new_start = 16'hFFFF;
                        2: new_start = 16'($urandom_range(0, 65535));
                        default: new_start = 16'($urandom_range(1, 8));
                    endcase
                    write_start_position(new_start);
                end
                default: run_search_sequence();
            endcase
        end

        // ---- wind down ----
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        run_done <= 1'b1;
        repeat (2) @(posedge aclk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
